/* rtl/rsas_pkg.sv */
// Shared types and constants for the rotated sorted array search unit.
// No dependencies; every other file of the block but rsas_ram uses this package.
`default_nettype none

package rsas_pkg;

  // Default geometry of the element store.
  localparam int unsigned DEPTH_DEFAULT       = 1024;
  localparam int unsigned VALUE_WIDTH_DEFAULT = 32;

  // Width of the reported position field.
  localparam int unsigned POS_W = 10;

  // Item command codes.
  localparam logic CMD_STORE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  // Controller states, one-hot.
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CHECK  = 6'b000010,
    S_RD_HI  = 6'b000100,
    S_RD_MID = 6'b001000,
    S_EVAL   = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store;   // write the incoming word into the store
    logic start;   // begin a search over the stored elements
    logic check;   // test the range, read lo (rotated) or mid (plain)
    logic rd_hi;   // capture the lo element, read hi
    logic rd_mid;  // capture the hi element, read mid
    logic eval;    // compare the mid element and narrow the range
    logic emit;    // move the result into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;        // no elements stored
    logic range_empty;  // lo has passed hi
    logic plain;        // range is known to be sorted
    logic hit;          // mid element equals the target
    logic out_free;     // output register can take a word this cycle
  } dp_status_t;

endpackage

`default_nettype wire

/* rtl/rsas_ifs.sv */
// Valid/ready channel interfaces of the rotated sorted array search unit.
// Depends on rsas_pkg for the value and position widths.
`default_nettype none

interface rsas_in_if #(
  parameter int unsigned ValueWidth = rsas_pkg::VALUE_WIDTH_DEFAULT
) ();
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic signed [ValueWidth-1:0] value;
  logic                         restart;

  modport source (output valid, cmd, value, restart, input ready);
  modport sink   (input valid, cmd, value, restart, output ready);
endinterface

interface rsas_out_if ();
  import rsas_pkg::*;

  logic             valid;
  logic             ready;
  logic             found;
  logic [POS_W-1:0] position;

  modport source (output valid, found, position, input ready);
  modport sink   (input valid, found, position, output ready);
endinterface

`default_nettype wire

/* rtl/rsas_ram.sv */
// Generic single-port RAM with a registered read port.
// No dependencies.
`default_nettype none

module rsas_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] addr_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/rsas_ctrl.sv */
// Sequencing state machine of the rotated sorted array search unit.
// Depends on rsas_pkg for the state, command and status types.
`default_nettype none

module rsas_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 in_cmd_i,
  output logic                      in_ready_o,
  input  wire rsas_pkg::dp_status_t status_i,
  output rsas_pkg::dp_cmd_t         cmd_o
);
  import rsas_pkg::*;

  state_e state_q, state_d;
  logic   in_acc;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_cmd_i == CMD_STORE) begin
            cmd_o.store = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            state_d     = status_i.empty ? S_DONE : S_CHECK;
          end
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        if (status_i.range_empty) begin
          state_d = S_DONE;
        end else if (status_i.plain) begin
          state_d = S_EVAL;
        end else begin
          state_d = S_RD_HI;
        end
      end
      S_RD_HI: begin
        cmd_o.rd_hi = 1'b1;
        state_d     = S_RD_MID;
      end
      S_RD_MID: begin
        cmd_o.rd_mid = 1'b1;
        state_d      = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = status_i.hit ? S_DONE : S_CHECK;
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/rsas_dp.sv */
// Datapath of the rotated sorted array search unit: element store, search
// bounds, compare logic and output register. Depends on rsas_pkg and rsas_ram.
`default_nettype none

module rsas_dp #(
  parameter int unsigned Depth      = rsas_pkg::DEPTH_DEFAULT,
  parameter int unsigned ValueWidth = rsas_pkg::VALUE_WIDTH_DEFAULT
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire rsas_pkg::dp_cmd_t            cmd_i,
  output rsas_pkg::dp_status_t              status_o,
  input  wire logic signed [ValueWidth-1:0] in_value_i,
  input  wire logic                         in_restart_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic                              out_found_o,
  output logic [rsas_pkg::POS_W-1:0]        out_position_o
);
  import rsas_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  // Signed bounds: lo may reach Depth and hi may fall to minus one.
  localparam int unsigned IW = AW + 2;
  localparam logic signed [IW-1:0] One = IW'(1);

  logic [ValueWidth-1:0] in_key;
  logic [ValueWidth-1:0] target_q, lo_val_q, hi_val_q, rdata;
  logic [CW-1:0]         count_q;
  logic                  full;
  logic signed [IW-1:0]  lo_q, hi_q, cnt_s, sum_c, mid_s;
  logic [AW-1:0]         mid_c, mid_q, addr;
  logic                  we;
  logic                  plain_q, first_q;
  logic                  res_found_q;
  logic [POS_W-1:0]      res_pos_q, mid_pos;
  logic [AW+POS_W-1:0]   mid_pos_ext;
  logic                  out_valid_q, out_found_q;
  logic [POS_W-1:0]      out_pos_q;

  // Order-preserving unsigned key: flip the sign bit.
  assign in_key = {~in_value_i[ValueWidth-1], in_value_i[ValueWidth-2:0]};

  assign full  = (count_q == CW'(Depth));
  assign cnt_s = $signed(IW'(count_q));
  assign sum_c = lo_q + hi_q + One;
  assign mid_c = sum_c[AW:1];
  assign mid_s = $signed({2'b00, mid_q});

  assign mid_pos_ext = {{POS_W{1'b0}}, mid_q};
  assign mid_pos     = mid_pos_ext[POS_W-1:0];

  // Single RAM port: writes only happen while idle, reads only during a search.
  always_comb begin
    we   = 1'b0;
    addr = mid_c;
    if (cmd_i.store) begin
      we   = in_restart_i || !full;
      addr = in_restart_i ? '0 : count_q[AW-1:0];
    end else if (cmd_i.check) begin
      addr = plain_q ? mid_c : lo_q[AW-1:0];
    end else if (cmd_i.rd_hi) begin
      addr = hi_q[AW-1:0];
    end
  end

  rsas_ram #(
    .Width (ValueWidth),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .addr_i  (addr),
    .wdata_i (in_key),
    .rdata_o (rdata)
  );

  // Element count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.store) begin
      if (in_restart_i) begin
        count_q <= CW'(1);
      end else if (!full) begin
        count_q <= count_q + CW'(1);
      end
    end
  end

  // Search state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plain_q     <= 1'b0;
      first_q     <= 1'b0;
      res_found_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        plain_q     <= 1'b0;
        first_q     <= 1'b1;
        res_found_q <= 1'b0;
      end
      if (cmd_i.rd_mid) begin
        first_q <= 1'b0;
        if (first_q && (lo_val_q < rdata)) begin
          plain_q <= 1'b1;
        end
      end
      if (cmd_i.eval) begin
        if (rdata == target_q) begin
          res_found_q <= 1'b1;
        end else if (!plain_q) begin
          if (lo_val_q < rdata) begin
            if ((target_q < rdata) && (lo_val_q <= target_q)) begin
              plain_q <= 1'b1;
            end
          end else if ((target_q > rdata) && (target_q <= hi_val_q)) begin
            plain_q <= 1'b1;
          end
        end
      end
    end
  end

  // Bounds and captured elements.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      target_q  <= in_key;
      lo_q      <= '0;
      hi_q      <= cnt_s - One;
      res_pos_q <= '0;
    end
    if (cmd_i.check || cmd_i.rd_mid) begin
      mid_q <= mid_c;
    end
    if (cmd_i.rd_hi) begin
      lo_val_q <= rdata;
    end
    if (cmd_i.rd_mid) begin
      hi_val_q <= rdata;
    end
    if (cmd_i.eval) begin
      if (rdata == target_q) begin
        res_pos_q <= mid_pos;
      end else if (plain_q) begin
        if (rdata < target_q) begin
          lo_q <= mid_s + One;
        end else begin
          hi_q <= mid_s - One;
        end
      end else if (lo_val_q < rdata) begin
        // Left half is sorted: search it if it brackets the target.
        if ((target_q < rdata) && (lo_val_q <= target_q)) begin
          hi_q <= mid_s - One;
        end else begin
          lo_q <= mid_s + One;
        end
      end else begin
        // Right half is sorted.
        if ((target_q > rdata) && (target_q <= hi_val_q)) begin
          lo_q <= mid_s + One;
        end else begin
          hi_q <= mid_s - One;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_found_q <= res_found_q;
      out_pos_q   <= res_pos_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_found_o    = out_found_q;
  assign out_position_o = out_pos_q;

  assign status_o.empty       = (count_q == '0);
  assign status_o.range_empty = (lo_q > hi_q);
  assign status_o.plain       = plain_q;
  assign status_o.hit         = (rdata == target_q);
  assign status_o.out_free    = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

/* rtl/rotated_sorted_array_search_unit.sv */
// Top level of the rotated sorted array search unit.
// Depends on rsas_pkg, rsas_ifs, rsas_ctrl, rsas_dp and rsas_ram.
//
//   channel  direction  words                        payload
//   in_i     sink       store or search command      cmd, value, restart
//   out_o    source     one word per search          found, position
//
// A store word writes the next element of the single-port store; with restart
// set it writes the first element and the count starts over at one, and a
// store word without restart writes nothing once the store is full. A search
// word is set up, then each halving step reads lo, hi and mid while the range
// is still rotated, and the mid element alone once the range is known to be
// sorted; the single memory port sets this pace.
// Reset clears the element count and control state; the store contents are
// left as they are. A search result waits in the output register while the
// next word is taken; a second result stalls the search until out_o drains.
`default_nettype none

module rotated_sorted_array_search_unit #(
  parameter int unsigned DEPTH       = rsas_pkg::DEPTH_DEFAULT,
  parameter int unsigned VALUE_WIDTH = rsas_pkg::VALUE_WIDTH_DEFAULT
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rsas_in_if.sink   in_i,
  rsas_out_if.source out_o
);
  import rsas_pkg::*;

  // Command and status between the sequencer and the datapath.
  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // The controller decides what happens each cycle; it sees the input handshake,
  // the command bit and the datapath status, never the payload values.
  rsas_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_cmd_i   (in_i.cmd),
    .in_ready_o (in_i.ready),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  // The datapath owns the element store, the search bounds and the output
  // register, and carries out whatever the controller commands.
  rsas_dp #(
    .Depth      (DEPTH),
    .ValueWidth (VALUE_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (dp_cmd),
    .status_o       (dp_status),
    .in_value_i     (in_i.value),
    .in_restart_i   (in_i.restart),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .out_found_o    (out_o.found),
    .out_position_o (out_o.position)
  );

endmodule

`default_nettype wire
